>>> sv/tbdal_pkg.sv
// Shared widths, register indexes, reset values and types of the button level unit.
package tbdal_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int TIME_WIDTH_MAX = 64;
  localparam int NOW_W          = 32;
  localparam int INTERVAL_W     = 16;
  localparam int LEVEL_W        = 8;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_INDEX_W    = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TIME   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_INTERVAL = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEVEL       = 2'd2;

  localparam logic [INTERVAL_W-1:0] DEBOUNCE_TIME_RST   = 16'd50;
  localparam logic [INTERVAL_W-1:0] REPEAT_INTERVAL_RST = 16'd200;
  localparam logic [LEVEL_W-1:0]    MAX_LEVEL_RST       = 8'd12;

  // Steps one button gives in one poll: the debounced first step and a repeat step.
  typedef struct packed {
    logic first;
    logic repeat_hit;
  } btn_steps_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               changed;
    logic               up_step;
    logic               down_step;
  } result_t;

endpackage

>>> sv/tbdal_button.sv
// Debounce and auto-repeat timer state of one button.
module tbdal_button #(
  parameter int TIME_WIDTH = tbdal_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                enable,
  input  logic [TIME_WIDTH-1:0]               now,
  input  logic                                pressed,
  input  logic [tbdal_pkg::INTERVAL_W-1:0]    debounce_time,
  input  logic [tbdal_pkg::INTERVAL_W-1:0]    repeat_interval,
  output tbdal_pkg::btn_steps_t               steps
);

  localparam int CMP_W = (TIME_WIDTH > tbdal_pkg::INTERVAL_W) ? TIME_WIDTH
                                                               : tbdal_pkg::INTERVAL_W;

  logic                  previous;
  logic                  held;
  logic [TIME_WIDTH-1:0] press_time;
  logic [TIME_WIDTH-1:0] repeat_time;

  logic                  previous_next;
  logic                  held_next;
  logic [TIME_WIDTH-1:0] press_time_next;
  logic [TIME_WIDTH-1:0] repeat_time_next;

  logic [TIME_WIDTH-1:0] since_press;
  logic [TIME_WIDTH-1:0] since_repeat;
  logic                  held_mid;
  logic [TIME_WIDTH-1:0] repeat_mid;

  always_comb begin
    press_time_next = (pressed && !previous) ? now : press_time;
    since_press     = now - press_time_next;
    steps.first     = pressed && !held &&
                      (CMP_W'(since_press) >= CMP_W'(debounce_time));
    held_mid        = held || steps.first;
    repeat_mid      = steps.first ? now : repeat_time;
    // after a first step the gap is zero, so a repeat follows only at a zero interval
    since_repeat     = now - repeat_mid;
    steps.repeat_hit = pressed && held_mid &&
                       (CMP_W'(since_repeat) >= CMP_W'(repeat_interval));
    repeat_time_next = steps.repeat_hit ? now : repeat_mid;
    held_next        = pressed && held_mid;
    previous_next    = pressed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous    <= 1'b0;
      held        <= 1'b0;
      press_time  <= '0;
      repeat_time <= '0;
    end else if (enable) begin
      previous    <= previous_next;
      held        <= held_next;
      press_time  <= press_time_next;
      repeat_time <= repeat_time_next;
    end
  end

endmodule

>>> sv/tbdal_level.sv
// Saturating level register moved by the up steps, then the down steps, of one poll.
module tbdal_level (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              enable,
  input  logic [tbdal_pkg::LEVEL_W-1:0]     max_level,
  input  tbdal_pkg::btn_steps_t             up,
  input  tbdal_pkg::btn_steps_t             down,
  output logic [tbdal_pkg::LEVEL_W-1:0]     level_next
);

  logic [tbdal_pkg::LEVEL_W-1:0] level;
  logic [tbdal_pkg::LEVEL_W-1:0] lvl_a;
  logic [tbdal_pkg::LEVEL_W-1:0] lvl_b;
  logic [tbdal_pkg::LEVEL_W-1:0] lvl_c;

  function automatic logic [tbdal_pkg::LEVEL_W-1:0] bump_up(
    input logic [tbdal_pkg::LEVEL_W-1:0] v,
    input logic [tbdal_pkg::LEVEL_W-1:0] mx
  );
    logic [tbdal_pkg::LEVEL_W:0] s;
    s = {1'b0, v} + {{tbdal_pkg::LEVEL_W{1'b0}}, 1'b1};
    if (s > {1'b0, mx}) return mx;
    return s[tbdal_pkg::LEVEL_W-1:0];
  endfunction

  function automatic logic [tbdal_pkg::LEVEL_W-1:0] bump_down(
    input logic [tbdal_pkg::LEVEL_W-1:0] v,
    input logic [tbdal_pkg::LEVEL_W-1:0] mx
  );
    logic [tbdal_pkg::LEVEL_W-1:0] t;
    t = (v == '0) ? '0 : v - {{(tbdal_pkg::LEVEL_W-1){1'b0}}, 1'b1};
    // a level left above a lowered limit clamps after the drop
    if (t > mx) return mx;
    return t;
  endfunction

  always_comb begin
    lvl_a      = up.first        ? bump_up(level, max_level)   : level;
    lvl_b      = up.repeat_hit   ? bump_up(lvl_a, max_level)   : lvl_a;
    lvl_c      = down.first      ? bump_down(lvl_b, max_level) : lvl_b;
    level_next = down.repeat_hit ? bump_down(lvl_c, max_level) : lvl_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (enable) begin
      level <= level_next;
    end
  end

endmodule

>>> sv/tbdal_out_buf.sv
// Two-entry result queue that lets a poll enter while a result waits on a stalled receiver.
module tbdal_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tbdal_pkg::result_t   push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tbdal_pkg::result_t   out_data
);

  logic [1:0]         count;
  logic               pop;
  tbdal_pkg::result_t slot0;
  tbdal_pkg::result_t slot1;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot0;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // hold the head while stalled; advance the waiting entry on a transaction
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        slot0 <= slot1;
      end else if (push) begin
        slot0 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
    if (pop && push && count == 2'd2) begin
      slot1 <= push_data;
    end
  end

endmodule

>>> sv/two_button_debounce_autorepeat_level_unit.sv
// Top level of the two-button debounce and auto-repeat level unit.
//
// Each input transaction is one poll: a millisecond timestamp (now_time) and
// the raw levels of the up and down buttons. Every poll gives exactly one
// result transaction: the level after the poll's steps, a changed flag and
// one step flag for each button. The up button is handled before the down one.
// Both channels move a transaction at a rising edge where valid is high and
// stall is low. Throughput is one poll per cycle when not stalled; each
// result enters a two-entry result queue when its poll is taken, as all timer
// and level logic sits before the queue. With a result waiting on a stalled
// receiver one more poll is still taken; in_stall rises only when both queue
// entries are full. The user must see that registers are written through
// cfg_write, cfg_index and cfg_data only while the unit is idle; the unit
// does not enforce it. An index beyond max_level is ignored. Reset clears
// the button state, the level and the queue, and loads the registers with
// debounce 50, repeat interval 200 and maximum level 12.
module two_button_debounce_autorepeat_level_unit #(
  parameter int TIME_WIDTH = tbdal_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tbdal_pkg::NOW_W-1:0]         now_time,
  input  logic                                up_pressed,
  input  logic                                down_pressed,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tbdal_pkg::LEVEL_W-1:0]       level,
  output logic                                changed,
  output logic                                up_step,
  output logic                                down_step,
  input  logic                                cfg_write,
  input  logic [tbdal_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tbdal_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [tbdal_pkg::INTERVAL_W-1:0] debounce_time;
  logic [tbdal_pkg::INTERVAL_W-1:0] repeat_interval;
  logic [tbdal_pkg::LEVEL_W-1:0]    max_level;

  logic [tbdal_pkg::TIME_WIDTH_MAX-1:0] now_ext;
  logic [TIME_WIDTH-1:0]                now;
  logic                                 accept;
  logic                                 buf_full;
  tbdal_pkg::btn_steps_t                up_steps;
  tbdal_pkg::btn_steps_t                down_steps;
  logic [tbdal_pkg::LEVEL_W-1:0]        level_next;
  tbdal_pkg::result_t                   result;
  tbdal_pkg::result_t                   head;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time   <= tbdal_pkg::DEBOUNCE_TIME_RST;
      repeat_interval <= tbdal_pkg::REPEAT_INTERVAL_RST;
      max_level       <= tbdal_pkg::MAX_LEVEL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        tbdal_pkg::CFG_DEBOUNCE_TIME:   debounce_time   <= cfg_data;
        tbdal_pkg::CFG_REPEAT_INTERVAL: repeat_interval <= cfg_data;
        tbdal_pkg::CFG_MAX_LEVEL:       max_level       <= cfg_data[tbdal_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign now_ext  = tbdal_pkg::TIME_WIDTH_MAX'(now_time);
  assign now      = now_ext[TIME_WIDTH-1:0];
  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  tbdal_button #(.TIME_WIDTH(TIME_WIDTH)) u_up (
    .clk             (clk),
    .rst             (rst),
    .enable          (accept),
    .now             (now),
    .pressed         (up_pressed),
    .debounce_time   (debounce_time),
    .repeat_interval (repeat_interval),
    .steps           (up_steps)
  );

  tbdal_button #(.TIME_WIDTH(TIME_WIDTH)) u_down (
    .clk             (clk),
    .rst             (rst),
    .enable          (accept),
    .now             (now),
    .pressed         (down_pressed),
    .debounce_time   (debounce_time),
    .repeat_interval (repeat_interval),
    .steps           (down_steps)
  );

  tbdal_level u_level (
    .clk        (clk),
    .rst        (rst),
    .enable     (accept),
    .max_level  (max_level),
    .up         (up_steps),
    .down       (down_steps),
    .level_next (level_next)
  );

  always_comb begin
    result.level     = level_next;
    result.up_step   = up_steps.first || up_steps.repeat_hit;
    result.down_step = down_steps.first || down_steps.repeat_hit;
    result.changed   = result.up_step || result.down_step;
  end

  tbdal_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (head)
  );

  assign level     = head.level;
  assign changed   = head.changed;
  assign up_step   = head.up_step;
  assign down_step = head.down_step;

endmodule

>>> dv/two_button_debounce_autorepeat_level_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the two-button debounce and auto-repeat level unit.
module two_button_debounce_autorepeat_level_unit_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [tbdal_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [tbdal_pkg::NOW_W-1:0] t;
    logic                        up;
    logic                        dn;
  } poll_t;

  typedef struct packed {
    logic                        prev;
    logic [tbdal_pkg::NOW_W-1:0] press_at;
    logic [tbdal_pkg::NOW_W-1:0] step_at;
    logic                        held;
  } btn_t;

  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  logic                              in_stall;
  logic [tbdal_pkg::NOW_W-1:0]       now_time;
  logic                              up_pressed;
  logic                              down_pressed;
  logic                              out_valid;
  logic                              out_stall;
  logic [tbdal_pkg::LEVEL_W-1:0]     level;
  logic                              changed;
  logic                              up_step;
  logic                              down_step;
  logic                              cfg_write;
  logic [tbdal_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [tbdal_pkg::CFG_DATA_W-1:0]  cfg_data;

  // Predicted unit state and register copies
  btn_t                             up_btn;
  btn_t                             dn_btn;
  logic [tbdal_pkg::LEVEL_W-1:0]    lvl_now;
  logic [tbdal_pkg::INTERVAL_W-1:0] debounce_cfg;
  logic [tbdal_pkg::INTERVAL_W-1:0] repeat_ms;
  logic [tbdal_pkg::LEVEL_W-1:0]    level_cap;

  poll_t              polls_q[$];
  tbdal_pkg::result_t level_reports_q[$];
  int                 polls_total;
  int                 polls_done;
  logic               poll_taken;
  int                 send_idle_pct;
  int                 stall_pct_now;
  int                 hold_left;
  int                 cycles;
  int                 errs;
  logic [tbdal_pkg::NOW_W-1:0] clock_ms;

  two_button_debounce_autorepeat_level_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .now_time     (now_time),
    .up_pressed   (up_pressed),
    .down_pressed (down_pressed),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .level        (level),
    .changed      (changed),
    .up_step      (up_step),
    .down_step    (down_step),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [tbdal_pkg::LEVEL_W-1:0] nudge(
    logic [tbdal_pkg::LEVEL_W-1:0] lv,
    logic go_up
  );
    int v;
    v = go_up ? int'(lv) + 1 : int'(lv) - 1;
    if (v < 0) v = 0;
    if (v > int'(level_cap)) v = int'(level_cap);
    return v[tbdal_pkg::LEVEL_W-1:0];
  endfunction

  task automatic scan_button(inout btn_t b, input logic [tbdal_pkg::NOW_W-1:0] t,
                             input logic pressed, input logic go_up,
                             output logic stepped);
    logic [tbdal_pkg::NOW_W-1:0] since;
    stepped = 1'b0;
    if (pressed && !b.prev) b.press_at = t;
    since = t - b.press_at;
    if (pressed && !b.held && since >= tbdal_pkg::NOW_W'(debounce_cfg)) begin
      b.held = 1'b1;
      b.step_at = t;
      lvl_now = nudge(lvl_now, go_up);
      stepped = 1'b1;
    end
    // a zero interval lets the repeat fire in the same poll as the first step
    since = t - b.step_at;
    if (pressed && b.held && since >= tbdal_pkg::NOW_W'(repeat_ms)) begin
      b.step_at = t;
      lvl_now = nudge(lvl_now, go_up);
      stepped = 1'b1;
    end
    if (!pressed) b.held = 1'b0;
    b.prev = pressed;
  endtask

  task automatic poll_buttons(input poll_t p);
    tbdal_pkg::result_t r;
    logic us;
    logic ds;
    scan_button(up_btn, p.t, p.up, 1'b1, us);
    scan_button(dn_btn, p.t, p.dn, 1'b0, ds);
    r.level     = lvl_now;
    r.changed   = us | ds;
    r.up_step   = us;
    r.down_step = ds;
    level_reports_q.push_back(r);
  endtask

  // Driver: hold the payload until the transaction is taken
  always @(negedge clk) begin : drive_polls
    poll_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || poll_taken) begin
      if (poll_taken) begin
        nxt = polls_q.pop_front();
        poll_taken = 1'b0;
      end
      if (polls_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = polls_q[0];
        in_valid     <= 1'b1;
        now_time     <= nxt.t;
        up_pressed   <= nxt.up;
        down_pressed <= nxt.dn;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: a long hold-off first, then random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct_now);
    end
  end

  // Monitor: predict on each input transaction, check each result transaction
  always @(posedge clk) begin : watch
    tbdal_pkg::result_t want;
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else if (!rst) begin
      if (in_valid && !in_stall) begin
        poll_buttons('{t: now_time, up: up_pressed, dn: down_pressed});
        polls_done = polls_done + 1;
        poll_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (level_reports_q.size() == 0) begin
          $error("result with nothing expected: level %0d", level);
          errs = errs + 1;
        end else begin
          want = level_reports_q.pop_front();
          if (level !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, level);
            errs = errs + 1;
          end
          if (changed !== want.changed) begin
            $error("changed: expected %0d, got %0d", want.changed, changed);
            errs = errs + 1;
          end
          if (up_step !== want.up_step) begin
            $error("up_step: expected %0d, got %0d", want.up_step, up_step);
            errs = errs + 1;
          end
          if (down_step !== want.down_step) begin
            $error("down_step: expected %0d, got %0d", want.down_step, down_step);
            errs = errs + 1;
          end
        end
      end
    end
  end

  task automatic add_poll(input logic [tbdal_pkg::NOW_W-1:0] t, input logic up,
                          input logic dn);
    polls_q.push_back('{t: t, up: up, dn: dn});
    polls_total = polls_total + 1;
  endtask

  task automatic write_reg(input logic [tbdal_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [tbdal_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      tbdal_pkg::CFG_DEBOUNCE_TIME:   debounce_cfg = val;
      tbdal_pkg::CFG_REPEAT_INTERVAL: repeat_ms = val;
      tbdal_pkg::CFG_MAX_LEVEL:       level_cap = val[tbdal_pkg::LEVEL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    while (!(polls_done == polls_total && level_reports_q.size() == 0)) @(negedge clk);
  endtask

  // Mostly held and released runs with drifting time, some glitches and random jumps
  task automatic add_session(input int n);
    int k;
    int up_run;
    int dn_run;
    int gap;
    logic up_lv;
    logic dn_lv;
    up_run = 0;
    dn_run = 0;
    up_lv = 1'b0;
    dn_lv = 1'b0;
    clock_ms = $urandom;
    for (k = 0; k < n; k++) begin
      if (up_run == 0) begin
        up_lv = ~up_lv;
        up_run = up_lv ? $urandom_range(1, 20) : $urandom_range(1, 6);
      end
      if (dn_run == 0) begin
        dn_lv = ~dn_lv;
        dn_run = dn_lv ? $urandom_range(1, 20) : $urandom_range(1, 6);
      end
      up_run = up_run - 1;
      dn_run = dn_run - 1;
      case ($urandom_range(0, 6))
        0: gap = $urandom_range(0, 2);
        1: gap = $urandom_range(0, int'(debounce_cfg) + 3);
        2: gap = $urandom_range(0, int'(repeat_ms) + 3);
        3: begin
          gap = $urandom_range(0, 2);
          gap = gap - 1 + int'(repeat_ms);
        end
        4: begin
          gap = $urandom_range(0, 2);
          gap = gap - 1 + int'(debounce_cfg);
        end
        default: gap = $urandom_range(0, 2000);
      endcase
      if (gap < 0) gap = 0;
      clock_ms = clock_ms + tbdal_pkg::NOW_W'(gap);
      if ($urandom_range(0, 9) == 0)
        add_poll($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else
        add_poll(clock_ms, up_lv, dn_lv);
    end
  endtask

  task automatic run_phase(input int n, input int send_pct, input int stall_pct,
                           input int hold);
    send_idle_pct = send_pct;
    stall_pct_now = stall_pct;
    hold_left = hold;
    add_session(n);
    wait_idle();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    now_time = '0;
    up_pressed = 1'b0;
    down_pressed = 1'b0;
    out_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = tbdal_pkg::CFG_DEBOUNCE_TIME;
    cfg_data = '0;
    up_btn = '0;
    dn_btn = '0;
    lvl_now = '0;
    debounce_cfg = tbdal_pkg::DEBOUNCE_TIME_RST;
    repeat_ms = tbdal_pkg::REPEAT_INTERVAL_RST;
    level_cap = tbdal_pkg::MAX_LEVEL_RST;
    polls_total = 0;
    polls_done = 0;
    poll_taken = 1'b0;
    send_idle_pct = 0;
    stall_pct_now = 0;
    hold_left = 0;
    cycles = 0;
    errs = 0;
    clock_ms = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Debounce, repeat, both buttons, step at the floor, timestamp wrap
    add_poll(32'd0, 1'b0, 1'b0);
    add_poll(32'd10, 1'b1, 1'b0);
    add_poll(32'd59, 1'b1, 1'b0);
    add_poll(32'd60, 1'b1, 1'b0);
    add_poll(32'd259, 1'b1, 1'b0);
    add_poll(32'd260, 1'b1, 1'b0);
    add_poll(32'd300, 1'b0, 1'b0);
    add_poll(32'd310, 1'b1, 1'b1);
    add_poll(32'd360, 1'b1, 1'b1);
    add_poll(32'd361, 1'b0, 1'b0);
    add_poll(32'd400, 1'b0, 1'b1);
    add_poll(32'd450, 1'b0, 1'b1);
    add_poll(32'd650, 1'b0, 1'b1);
    add_poll(32'd850, 1'b0, 1'b1);
    add_poll(32'd900, 1'b0, 1'b0);
    add_poll(32'hFFFF_FFF0, 1'b1, 1'b0);
    add_poll(32'h0000_0021, 1'b1, 1'b0);
    add_poll(32'h0000_0022, 1'b1, 1'b0);
    add_poll(32'hFFFF_FFFF, 1'b0, 1'b0);
    wait_idle();

    // Zero debounce and zero repeat: double step on the press; spare index is ignored
    write_reg(tbdal_pkg::CFG_DEBOUNCE_TIME, 16'd0);
    write_reg(tbdal_pkg::CFG_REPEAT_INTERVAL, 16'd0);
    write_reg(tbdal_pkg::CFG_MAX_LEVEL, 16'd255);
    write_reg(CFG_SPARE, 16'hFFFF);
    add_poll(32'd1000, 1'b1, 1'b0);
    add_poll(32'd1001, 1'b1, 1'b0);
    add_poll(32'd1001, 1'b1, 1'b0);
    add_poll(32'd1002, 1'b0, 1'b0);
    wait_idle();

    // Lower the ceiling under the level; upper data bits must be dropped
    write_reg(tbdal_pkg::CFG_MAX_LEVEL, 16'hFF03);
    add_poll(32'd1010, 1'b0, 1'b1);
    add_poll(32'd1011, 1'b0, 1'b0);
    wait_idle();
    write_reg(tbdal_pkg::CFG_MAX_LEVEL, 16'd0);
    add_poll(32'd1020, 1'b1, 1'b1);
    add_poll(32'd1021, 1'b0, 1'b0);
    wait_idle();

    // Random phases; the first one holds the receiver off long enough to fill the unit
    write_reg(tbdal_pkg::CFG_DEBOUNCE_TIME, 16'd50);
    write_reg(tbdal_pkg::CFG_REPEAT_INTERVAL, 16'd200);
    write_reg(tbdal_pkg::CFG_MAX_LEVEL, 16'd12);
    run_phase(120, 0, 0, 80);

    write_reg(tbdal_pkg::CFG_DEBOUNCE_TIME, 16'd0);
    write_reg(tbdal_pkg::CFG_REPEAT_INTERVAL, 16'd1);
    write_reg(tbdal_pkg::CFG_MAX_LEVEL, 16'd255);
    run_phase(120, 80, 0, 0);

    write_reg(tbdal_pkg::CFG_DEBOUNCE_TIME, 16'hFFFF);
    write_reg(tbdal_pkg::CFG_REPEAT_INTERVAL, 16'hFFFF);
    write_reg(tbdal_pkg::CFG_MAX_LEVEL, 16'd0);
    run_phase(60, 0, 80, 0);

    write_reg(tbdal_pkg::CFG_DEBOUNCE_TIME, 16'd7);
    write_reg(tbdal_pkg::CFG_REPEAT_INTERVAL, 16'd0);
    write_reg(tbdal_pkg::CFG_MAX_LEVEL, 16'd5);
    run_phase(100, 37, 37, 0);

    write_reg(tbdal_pkg::CFG_DEBOUNCE_TIME, 16'd30);
    write_reg(tbdal_pkg::CFG_REPEAT_INTERVAL, 16'd90);
    write_reg(tbdal_pkg::CFG_MAX_LEVEL, 16'd200);
    run_phase(100, 0, 0, 0);

    repeat (8) @(posedge clk);
    if (errs == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
